### hdl/bftm_pkg.sv
package bftm_pkg;

    // Default sizes of the stores.
    localparam int CODE_DEPTH_DEF  = 4096;
    localparam int TAPE_DEPTH_DEF  = 32768;
    localparam int STACK_DEPTH_DEF = 1024;

    // Fixed field widths.
    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 12;
    localparam int BYTE_W     = 8;
    localparam int ST_W       = 3;
    localparam int PC_OUT_W   = 13;
    localparam int PLEN_W     = 13;
    localparam int TSIZE_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [TSIZE_W-1:0] TAPE_SIZE_RST = 16'd30000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROG_LEN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPE_SIZE = 1'd1;

    // Item commands; the unused code changes nothing and reports like a load.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_NEED_IN = 3'd1;
    localparam logic [ST_W-1:0] ST_DONE    = 3'd2;
    localparam logic [ST_W-1:0] ST_BOUNDS  = 3'd3;
    localparam logic [ST_W-1:0] ST_UNBAL   = 3'd4;
    localparam logic [ST_W-1:0] ST_OVER    = 3'd5;

    // Program characters.
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic in_scan;
        logic exec_commit;
        logic scan_init;
        logic scan_step;
        logic scan_commit;
        logic clr_active;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic is_start;
        logic scan_end;
        logic clr_last;
        logic slot_free;
    } sts_t;

endpackage

### hdl/bftm_ctrl.sv
module bftm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  bftm_pkg::sts_t   sts,
    output bftm_pkg::ctl_t   ctl
);

    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SCAN_A = 3'd3;
    localparam logic [2:0] S_SCAN_B = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_stall = (state_reg != S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        ctl             = '0;
        ctl.in_scan     = (state_reg == S_SCAN_A) || (state_reg == S_SCAN_B);
        case (state_reg)
            S_CLR:
            begin
                ctl.clr_active = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.need_scan)
                begin
                    ctl.scan_init = 1'b1;
                    state_next    = S_SCAN_A;
                end
                else if (sts.slot_free)
                begin
                    ctl.exec_commit = 1'b1;
                    state_next      = sts.is_start ? S_CLR : S_IDLE;
                end
            end
            S_SCAN_A:
            begin
                state_next = S_SCAN_B;
            end
            S_SCAN_B:
            begin
                if (!sts.scan_end)
                begin
                    ctl.scan_step = 1'b1;
                    state_next    = S_SCAN_A;
                end
                else if (sts.slot_free)
                begin
                    ctl.scan_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register; reset starts with a clearing pass of the jump cache.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result is only loaded when the output register can take it.
    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec_commit || ctl.scan_commit) |-> sts.slot_free)
        else $error("result committed while output register is full");

    // An accepted item always moves the sequencer to the execute state in the following cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

    // The clearing pass ends in idle.
    a_clr_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR && sts.clr_last) |=> (state_reg == S_IDLE))
        else $error("clearing pass did not end in idle");

    // A scan read is entered only from execute or a previous scan step.
    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_A) |->
        ($past(state_reg) == S_EXEC || $past(state_reg) == S_SCAN_B))
        else $error("scan entered from an unexpected state");

endmodule

### hdl/bftm_dp.sv
module bftm_dp
#(
    parameter int CODE_DEPTH  = bftm_pkg::CODE_DEPTH_DEF,
    parameter int TAPE_DEPTH  = bftm_pkg::TAPE_DEPTH_DEF,
    parameter int STACK_DEPTH = bftm_pkg::STACK_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bftm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [bftm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [bftm_pkg::CMD_W-1:0]        cmd,
    input  logic [bftm_pkg::ADDR_W-1:0]       code_addr,
    input  logic [bftm_pkg::BYTE_W-1:0]       code_byte,
    input  logic                              in_valid,
    input  logic [bftm_pkg::BYTE_W-1:0]       in_byte,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [bftm_pkg::ST_W-1:0]         status,
    output logic                              out_valid,
    output logic [bftm_pkg::BYTE_W-1:0]       out_byte,
    output logic [bftm_pkg::PC_OUT_W-1:0]     pc_now,
    input  bftm_pkg::ctl_t                    ctl,
    output bftm_pkg::sts_t                    sts
);

    localparam int CA = $clog2(CODE_DEPTH);
    localparam int LW = $clog2(CODE_DEPTH + 1);
    localparam int DW = $clog2(TAPE_DEPTH);
    localparam int FW = $clog2(TAPE_DEPTH + 1);
    localparam int SA = $clog2(STACK_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int JW = CA + 1;

    // Configuration registers.
    logic [bftm_pkg::PLEN_W-1:0]  prog_len_reg;
    logic [bftm_pkg::TSIZE_W-1:0] tape_size_reg;

    // Latched item.
    logic [bftm_pkg::CMD_W-1:0]  cmd_reg;
    logic [bftm_pkg::ADDR_W-1:0] addr_reg;
    logic [bftm_pkg::BYTE_W-1:0] byte_reg;
    logic                        inv_reg;
    logic [bftm_pkg::BYTE_W-1:0] inb_reg;

    // Machine state.
    logic [LW-1:0]           pc_reg;
    logic [DW-1:0]           dp_reg;
    logic [SW-1:0]           depth_reg;
    logic [bftm_pkg::ST_W-1:0] run_st_reg;
    logic [FW-1:0]           fill_reg;
    logic [LW-1:0]           k_reg;
    logic [LW-1:0]           bal_reg;
    logic [CA-1:0]           clr_cnt_reg;

    // Result register.
    logic                          res_valid_reg;
    logic [bftm_pkg::ST_W-1:0]     status_reg;
    logic                          emit_reg;
    logic [bftm_pkg::BYTE_W-1:0]   emit_byte_reg;
    logic [LW-1:0]                 pc_out_reg;

    // Memories.
    logic [bftm_pkg::BYTE_W-1:0] code_mem  [CODE_DEPTH];
    logic [bftm_pkg::BYTE_W-1:0] tape_mem  [TAPE_DEPTH];
    logic [CA-1:0]               stack_mem [STACK_DEPTH];
    logic [JW-1:0]               cache_mem [CODE_DEPTH];
    logic [bftm_pkg::BYTE_W-1:0] code_q;
    logic [bftm_pkg::BYTE_W-1:0] tape_q;
    logic [CA-1:0]               stack_q;
    logic [JW-1:0]               cache_q;

    logic [CA-1:0] code_ra;
    logic [SW-1:0] depth_dec;
    logic          cache_we;
    logic [CA-1:0] cache_wa;
    logic [JW-1:0] cache_wd;

    // Derived limits.
    logic [31:0]   len32;
    logic [31:0]   tape32;
    logic [LW-1:0] eff_len;
    logic [bftm_pkg::BYTE_W-1:0] cur_cell;
    logic          addr_ok;
    logic [LW-1:0] pc_inc;

    // Execute results.
    logic [bftm_pkg::ST_W-1:0]   e_status;
    logic [bftm_pkg::ST_W-1:0]   e_run;
    logic                        e_emit;
    logic [bftm_pkg::BYTE_W-1:0] e_byte;
    logic [LW-1:0]               e_pc;
    logic [DW-1:0]               e_dp;
    logic [SW-1:0]               e_depth;
    logic [bftm_pkg::BYTE_W-1:0] e_cell;
    logic                        e_tape_we;
    logic                        e_push;
    logic                        e_cwe;
    logic                        e_code_we;
    logic                        e_need_scan;
    logic                        e_err;
    logic [bftm_pkg::ST_W-1:0]   e_err_code;
    logic [LW-1:0]               e_step_pc;

    // Scan results.
    logic                        s_fail;
    logic                        s_found;
    logic [LW-1:0]               s_k_inc;
    logic [LW-1:0]               s_bal_next;
    logic [bftm_pkg::ST_W-1:0]   s_status;
    logic [LW-1:0]               s_pc;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg  <= '0;
            tape_size_reg <= bftm_pkg::TAPE_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bftm_pkg::REG_PROG_LEN:  prog_len_reg  <= cfg_data[bftm_pkg::PLEN_W-1:0];
                bftm_pkg::REG_TAPE_SIZE: tape_size_reg <= cfg_data[bftm_pkg::TSIZE_W-1:0];
                default:                 prog_len_reg  <= prog_len_reg;
            endcase
        end
    end

    // Item capture on transfer.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= cmd;
            addr_reg <= code_addr;
            byte_reg <= code_byte;
            inv_reg  <= in_valid;
            inb_reg  <= in_byte;
        end
    end

    // Effective program length and tape size.
    always_comb
    begin
        if (32'(prog_len_reg) > CODE_DEPTH)
        begin
            len32 = CODE_DEPTH;
        end
        else
        begin
            len32 = 32'(prog_len_reg);
        end
        if (tape_size_reg == '0)
        begin
            tape32 = 32'd1;
        end
        else if (32'(tape_size_reg) > TAPE_DEPTH)
        begin
            tape32 = TAPE_DEPTH;
        end
        else
        begin
            tape32 = 32'(tape_size_reg);
        end
    end

    assign eff_len   = len32[LW-1:0];
    assign addr_ok   = (32'(addr_reg) < CODE_DEPTH);
    assign cur_cell  = (FW'(dp_reg) < fill_reg) ? tape_q : '0;
    assign pc_inc    = pc_reg + LW'(1);
    assign code_ra   = ctl.in_scan ? k_reg[CA-1:0] : pc_reg[CA-1:0];
    assign depth_dec = depth_reg - SW'(1);

    // Instruction execution.
    always_comb
    begin
        e_status    = run_st_reg;
        e_run       = run_st_reg;
        e_emit      = 1'b0;
        e_byte      = '0;
        e_pc        = pc_reg;
        e_dp        = dp_reg;
        e_depth     = depth_reg;
        e_cell      = cur_cell;
        e_tape_we   = 1'b0;
        e_push      = 1'b0;
        e_cwe       = 1'b0;
        e_code_we   = 1'b0;
        e_need_scan = 1'b0;
        e_err       = 1'b0;
        e_err_code  = bftm_pkg::ST_OK;
        e_step_pc   = pc_inc;
        case (cmd_reg)
            bftm_pkg::CMD_LOAD:
            begin
                e_code_we = addr_ok;
            end
            bftm_pkg::CMD_START:
            begin
                e_status = bftm_pkg::ST_OK;
            end
            bftm_pkg::CMD_STEP:
            begin
                if (run_st_reg != bftm_pkg::ST_OK)
                begin
                    e_status = run_st_reg;
                end
                else if (pc_reg >= eff_len)
                begin
                    e_status = bftm_pkg::ST_DONE;
                    e_run    = bftm_pkg::ST_DONE;
                end
                else
                begin
                    e_tape_we = 1'b1;
                    case (code_q)
                        bftm_pkg::CH_PLUS:  e_cell = cur_cell + 8'd1;
                        bftm_pkg::CH_MINUS: e_cell = cur_cell - 8'd1;
                        bftm_pkg::CH_RIGHT:
                        begin
                            if (32'(dp_reg) + 32'd1 >= tape32)
                            begin
                                e_err      = 1'b1;
                                e_err_code = bftm_pkg::ST_BOUNDS;
                            end
                            else
                            begin
                                e_dp = dp_reg + DW'(1);
                            end
                        end
                        bftm_pkg::CH_LEFT:
                        begin
                            if (dp_reg == '0)
                            begin
                                e_err      = 1'b1;
                                e_err_code = bftm_pkg::ST_BOUNDS;
                            end
                            else
                            begin
                                e_dp = dp_reg - DW'(1);
                            end
                        end
                        bftm_pkg::CH_DOT:
                        begin
                            e_emit = 1'b1;
                            e_byte = cur_cell;
                        end
                        bftm_pkg::CH_COMMA:
                        begin
                            if (!inv_reg)
                            begin
                                e_err      = 1'b1;
                                e_err_code = bftm_pkg::ST_NEED_IN;
                            end
                            else
                            begin
                                e_cell = inb_reg;
                            end
                        end
                        bftm_pkg::CH_OPEN:
                        begin
                            if (cur_cell == '0)
                            begin
                                if (cache_q[CA])
                                begin
                                    e_step_pc = LW'(cache_q[CA-1:0]) + LW'(1);
                                end
                                else
                                begin
                                    e_need_scan = 1'b1;
                                end
                            end
                            else if (32'(depth_reg) >= STACK_DEPTH)
                            begin
                                e_err      = 1'b1;
                                e_err_code = bftm_pkg::ST_OVER;
                            end
                            else
                            begin
                                e_push  = 1'b1;
                                e_depth = depth_reg + SW'(1);
                            end
                        end
                        bftm_pkg::CH_CLOSE:
                        begin
                            if (depth_reg == '0)
                            begin
                                e_err      = 1'b1;
                                e_err_code = bftm_pkg::ST_UNBAL;
                            end
                            else
                            begin
                                e_cwe = 1'b1;
                                if (cur_cell != '0)
                                begin
                                    e_step_pc = LW'(stack_q) + LW'(1);
                                end
                                else
                                begin
                                    e_depth = depth_dec;
                                end
                            end
                        end
                        default:
                        begin
                            e_cell = cur_cell;
                        end
                    endcase
                    if (e_err)
                    begin
                        e_status = e_err_code;
                        if (e_err_code != bftm_pkg::ST_NEED_IN)
                        begin
                            e_run = e_err_code;
                        end
                        e_emit = 1'b0;
                        e_byte = '0;
                        e_dp   = dp_reg;
                    end
                    else
                    begin
                        e_pc     = e_step_pc;
                        e_status = (e_step_pc >= eff_len) ? bftm_pkg::ST_DONE
                                                          : bftm_pkg::ST_OK;
                        e_run    = e_status;
                    end
                end
            end
            default:
            begin
                e_status = run_st_reg;
            end
        endcase
    end

    // Forward scan for the matching close bracket.
    always_comb
    begin
        s_fail     = (k_reg >= eff_len);
        s_found    = !s_fail && (code_q == bftm_pkg::CH_CLOSE) && (bal_reg == LW'(1));
        s_k_inc    = k_reg + LW'(1);
        s_bal_next = bal_reg;
        if (code_q == bftm_pkg::CH_OPEN)
        begin
            s_bal_next = bal_reg + LW'(1);
        end
        else if (code_q == bftm_pkg::CH_CLOSE)
        begin
            s_bal_next = bal_reg - LW'(1);
        end
        if (s_fail)
        begin
            s_status = bftm_pkg::ST_UNBAL;
            s_pc     = pc_reg;
        end
        else
        begin
            s_pc     = s_k_inc;
            s_status = (s_k_inc >= eff_len) ? bftm_pkg::ST_DONE : bftm_pkg::ST_OK;
        end
    end

    // Machine state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            dp_reg      <= '0;
            depth_reg   <= '0;
            run_st_reg  <= bftm_pkg::ST_OK;
            fill_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (ctl.exec_commit)
            begin
                if (cmd_reg == bftm_pkg::CMD_START)
                begin
                    pc_reg      <= '0;
                    dp_reg      <= '0;
                    depth_reg   <= '0;
                    run_st_reg  <= bftm_pkg::ST_OK;
                    fill_reg    <= '0;
                    clr_cnt_reg <= '0;
                end
                else
                begin
                    pc_reg     <= e_pc;
                    dp_reg     <= e_dp;
                    depth_reg  <= e_depth;
                    run_st_reg <= e_run;
                    if (e_tape_we && (FW'(dp_reg) >= fill_reg))
                    begin
                        fill_reg <= FW'(dp_reg) + FW'(1);
                    end
                end
            end
            else if (ctl.scan_commit)
            begin
                pc_reg     <= s_pc;
                run_st_reg <= s_status;
            end
            else if (ctl.clr_active)
            begin
                clr_cnt_reg <= clr_cnt_reg + CA'(1);
            end
        end
    end

    // Scan position and bracket balance.
    always_ff @(posedge clk)
    begin
        if (ctl.scan_init)
        begin
            k_reg   <= pc_reg;
            bal_reg <= '0;
        end
        else if (ctl.scan_step)
        begin
            k_reg   <= s_k_inc;
            bal_reg <= s_bal_next;
        end
    end

    // Code memory.
    always_ff @(posedge clk)
    begin
        if (ctl.exec_commit && e_code_we)
        begin
            code_mem[addr_reg[CA-1:0]] <= byte_reg;
        end
        code_q <= code_mem[code_ra];
    end

    // Data tape; cells past the fill mark read as zero.
    always_ff @(posedge clk)
    begin
        if (ctl.exec_commit && e_tape_we)
        begin
            tape_mem[dp_reg] <= e_cell;
        end
        tape_q <= tape_mem[dp_reg];
    end

    // Loop return stack.
    always_ff @(posedge clk)
    begin
        if (ctl.exec_commit && e_push)
        begin
            stack_mem[depth_reg[SA-1:0]] <= pc_reg[CA-1:0];
        end
        stack_q <= stack_mem[depth_dec[SA-1:0]];
    end

    // Jump cache write port: clearing pass, scan hit or executed close.
    always_comb
    begin
        cache_we = 1'b0;
        cache_wa = clr_cnt_reg;
        cache_wd = '0;
        if (ctl.clr_active)
        begin
            cache_we = 1'b1;
        end
        else if (ctl.scan_commit && s_found)
        begin
            cache_we = 1'b1;
            cache_wa = pc_reg[CA-1:0];
            cache_wd = {1'b1, k_reg[CA-1:0]};
        end
        else if (ctl.exec_commit && e_cwe)
        begin
            cache_we = 1'b1;
            cache_wa = stack_q;
            cache_wd = {1'b1, pc_reg[CA-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cache_we)
        begin
            cache_mem[cache_wa] <= cache_wd;
        end
        cache_q <= cache_mem[pc_reg[CA-1:0]];
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.exec_commit || ctl.scan_commit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec_commit)
        begin
            status_reg    <= e_status;
            emit_reg      <= e_emit;
            emit_byte_reg <= e_byte;
            pc_out_reg    <= (cmd_reg == bftm_pkg::CMD_START) ? '0 : e_pc;
        end
        else if (ctl.scan_commit)
        begin
            status_reg    <= s_status;
            emit_reg      <= 1'b0;
            emit_byte_reg <= '0;
            pc_out_reg    <= s_pc;
        end
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign out_valid = emit_reg;
    assign out_byte  = emit_byte_reg;
    assign pc_now    = bftm_pkg::PC_OUT_W'(pc_out_reg);

    // Status toward the controller.
    always_comb
    begin
        sts           = '0;
        sts.need_scan = e_need_scan;
        sts.is_start  = (cmd_reg == bftm_pkg::CMD_START);
        sts.scan_end  = s_fail || s_found;
        sts.clr_last  = (clr_cnt_reg == CA'(CODE_DEPTH - 1));
        sts.slot_free = !res_valid_reg || !res_stall;
    end

endmodule

### hdl/bracket_tape_machine_core.sv
// Channel   Direction  Handshake                Payload
// item      in         item_valid / item_stall  cmd, code_addr, code_byte, in_valid, in_byte
// result    out        res_valid / res_stall    status, out_valid, out_byte, pc_now
// config    in         cfg_we                   cfg_addr, cfg_data
//
// A load, start or plain step first reads the code, tape, stack and jump cache
// memories, then executes and loads the result register.
// A forward bracket scan on a jump cache miss reads and then checks each code byte scanned.
// After reset and after every start a clearing pass sweeps every jump cache entry;
// items are not taken during it, configuration writes are.
// The next item is taken while a result waits; a stalled result only holds the
// execute or scan commit that would overwrite it.
module bracket_tape_machine_core
#(
    parameter int CODE_DEPTH  = bftm_pkg::CODE_DEPTH_DEF,
    parameter int TAPE_DEPTH  = bftm_pkg::TAPE_DEPTH_DEF,
    parameter int STACK_DEPTH = bftm_pkg::STACK_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bftm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [bftm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [bftm_pkg::CMD_W-1:0]        cmd,
    input  logic [bftm_pkg::ADDR_W-1:0]       code_addr,
    input  logic [bftm_pkg::BYTE_W-1:0]       code_byte,
    input  logic                              in_valid,
    input  logic [bftm_pkg::BYTE_W-1:0]       in_byte,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [bftm_pkg::ST_W-1:0]         status,
    output logic                              out_valid,
    output logic [bftm_pkg::BYTE_W-1:0]       out_byte,
    output logic [bftm_pkg::PC_OUT_W-1:0]     pc_now
);

    bftm_pkg::ctl_t ctl;
    bftm_pkg::sts_t sts;

    // Sequencer.
    bftm_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .ctl        (ctl)
    );

    // Memories, machine registers and result register.
    bftm_dp
    #(
        .CODE_DEPTH  (CODE_DEPTH),
        .TAPE_DEPTH  (TAPE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .code_addr (code_addr),
        .code_byte (code_byte),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .pc_now    (pc_now),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

### tb/bracket_tape_machine_core_tb.sv
module bracket_tape_machine_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [bftm_pkg::BYTE_W-1:0] code_q_t[$];

    typedef struct {
        logic [bftm_pkg::CMD_W-1:0]  cmd;
        logic [bftm_pkg::ADDR_W-1:0] addr;
        logic [bftm_pkg::BYTE_W-1:0] cbyte;
        logic                        iv;
        logic [bftm_pkg::BYTE_W-1:0] ib;
    } item_t;

    typedef struct {
        logic [bftm_pkg::ST_W-1:0]     st;
        logic                          ov;
        logic [bftm_pkg::BYTE_W-1:0]   ob;
        logic [bftm_pkg::PC_OUT_W-1:0] pc;
    } res_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [bftm_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [bftm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            item_valid = 1'b0;
    logic                            item_stall;
    logic [bftm_pkg::CMD_W-1:0]      cmd = '0;
    logic [bftm_pkg::ADDR_W-1:0]     code_addr = '0;
    logic [bftm_pkg::BYTE_W-1:0]     code_byte = '0;
    logic                            in_valid = 1'b0;
    logic [bftm_pkg::BYTE_W-1:0]     in_byte = '0;
    logic                            res_valid;
    logic                            res_stall = 1'b0;
    logic [bftm_pkg::ST_W-1:0]       status;
    logic                            out_valid;
    logic [bftm_pkg::BYTE_W-1:0]     out_byte;
    logic [bftm_pkg::PC_OUT_W-1:0]   pc_now;

    bracket_tape_machine_core dut (.*);

    // Interpreter state mirrored by the predictor.
    logic [7:0]  code_mem [bftm_pkg::CODE_DEPTH_DEF];
    logic [7:0]  tape [bftm_pkg::TAPE_DEPTH_DEF];
    int          jump_to [bftm_pkg::CODE_DEPTH_DEF];
    bit          jump_ok [bftm_pkg::CODE_DEPTH_DEF];
    int          loop_ret [bftm_pkg::STACK_DEPTH_DEF];
    int          depth;
    int          pc;
    int          dp;
    logic [bftm_pkg::ST_W-1:0] run_st;
    int          prog_len;
    int          tape_sz;

    item_t item_q[$];
    res_t  pending_results[$];
    item_t cur;
    bit    took;
    bit    calm = 1'b0;
    bit    hold_req = 1'b0;
    int    hold_cnt = 0;
    int    errors = 0;
    int    n_items = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Clear the run state, as a start does.
    task automatic clear_run();
        for (int i = 0; i < bftm_pkg::TAPE_DEPTH_DEF; i++) tape[i] = '0;
        for (int i = 0; i < bftm_pkg::CODE_DEPTH_DEF; i++) jump_ok[i] = 1'b0;
        depth = 0;
        pc = 0;
        dp = 0;
        run_st = bftm_pkg::ST_OK;
    endtask

    // Execute one instruction and return its status.
    task automatic exec_insn(input item_t it, output logic [bftm_pkg::ST_W-1:0] st,
                             inout res_t r);
        int len;
        int ts;
        int npc;
        int bal;
        int k;
        int open_at;
        bit found;
        len = prog_len > bftm_pkg::CODE_DEPTH_DEF ? bftm_pkg::CODE_DEPTH_DEF : prog_len;
        ts = tape_sz == 0 ? 1 : (tape_sz > bftm_pkg::TAPE_DEPTH_DEF ?
                                 bftm_pkg::TAPE_DEPTH_DEF : tape_sz);
        npc = pc;
        case (code_mem[pc])
            bftm_pkg::CH_PLUS:  tape[dp] = tape[dp] + 8'd1;
            bftm_pkg::CH_MINUS: tape[dp] = tape[dp] - 8'd1;
            bftm_pkg::CH_RIGHT:
            begin
                if (dp + 1 >= ts)
                begin
                    st = bftm_pkg::ST_BOUNDS;
                    return;
                end
                dp++;
            end
            bftm_pkg::CH_LEFT:
            begin
                if (dp == 0)
                begin
                    st = bftm_pkg::ST_BOUNDS;
                    return;
                end
                dp--;
            end
            bftm_pkg::CH_DOT:
            begin
                r.ov = 1'b1;
                r.ob = tape[dp];
            end
            bftm_pkg::CH_COMMA:
            begin
                if (!it.iv)
                begin
                    st = bftm_pkg::ST_NEED_IN;
                    return;
                end
                tape[dp] = it.ib;
            end
            bftm_pkg::CH_OPEN:
            begin
                if (tape[dp] == 0)
                begin
                    if (jump_ok[pc])
                        npc = jump_to[pc];
                    else
                    begin
                        bal = 0;
                        found = 1'b0;
                        for (k = pc; k < len; k++)
                        begin
                            if (code_mem[k] == bftm_pkg::CH_OPEN) bal++;
                            if (code_mem[k] == bftm_pkg::CH_CLOSE)
                            begin
                                bal--;
                                if (bal == 0)
                                begin
                                    found = 1'b1;
                                    break;
                                end
                            end
                        end
                        if (!found)
                        begin
                            st = bftm_pkg::ST_UNBAL;
                            return;
                        end
                        jump_to[pc] = k;
                        jump_ok[pc] = 1'b1;
                        npc = k;
                    end
                end
                else
                begin
                    if (depth >= bftm_pkg::STACK_DEPTH_DEF)
                    begin
                        st = bftm_pkg::ST_OVER;
                        return;
                    end
                    loop_ret[depth] = pc;
                    depth++;
                end
            end
            bftm_pkg::CH_CLOSE:
            begin
                if (depth == 0)
                begin
                    st = bftm_pkg::ST_UNBAL;
                    return;
                end
                open_at = loop_ret[depth - 1];
                jump_to[open_at] = pc;
                jump_ok[open_at] = 1'b1;
                if (tape[dp] != 0) npc = open_at;
                else depth--;
            end
            default: ;
        endcase
        pc = npc + 1;
        st = pc >= len ? bftm_pkg::ST_DONE : bftm_pkg::ST_OK;
    endtask

    // Work out the result of one accepted item and queue it.
    task automatic interpret_item(input item_t it);
        res_t r;
        logic [bftm_pkg::ST_W-1:0] st;
        int len;
        r.ov = 1'b0;
        r.ob = '0;
        st = run_st;
        len = prog_len > bftm_pkg::CODE_DEPTH_DEF ? bftm_pkg::CODE_DEPTH_DEF : prog_len;
        if (it.cmd == bftm_pkg::CMD_LOAD)
            code_mem[it.addr] = it.cbyte;
        else if (it.cmd == bftm_pkg::CMD_START)
        begin
            clear_run();
            st = bftm_pkg::ST_OK;
        end
        else if (it.cmd == bftm_pkg::CMD_STEP && run_st == bftm_pkg::ST_OK)
        begin
            if (pc >= len) st = bftm_pkg::ST_DONE;
            else exec_insn(it, st, r);
            if (st != bftm_pkg::ST_NEED_IN) run_st = st;
        end
        r.st = st;
        r.pc = pc[bftm_pkg::PC_OUT_W-1:0];
        pending_results.push_back(r);
    endtask

    // Sample item transfers at the rising edge.
    always @(posedge clk)
    begin
        took = item_valid && !item_stall;
        if (took) interpret_item(cur);
    end

    // Item driver: a new item goes out only after the previous transfer.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || took))
        begin
            if (item_q.size() > 0 && (calm || $urandom_range(99) >= 17))
            begin
                cur = item_q.pop_front();
                item_valid <= 1'b1;
                cmd <= cur.cmd;
                code_addr <= cur.addr;
                code_byte <= cur.cbyte;
                in_valid <= cur.iv;
                in_byte <= cur.ib;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= !calm && ($urandom_range(99) < 17);
    end

    // Result monitor: compare each transfer with the oldest prediction.
    always @(posedge clk)
    begin
        res_t e;
        if (res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d pc %0d", $time, status, pc_now);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    errors++;
                end
                if (out_valid !== e.ov)
                begin
                    $display("%0t: out_valid expected %0d actual %0d", $time, e.ov,
                             out_valid);
                    errors++;
                end
                if (out_byte !== e.ob)
                begin
                    $display("%0t: out_byte expected %0d actual %0d", $time, e.ob,
                             out_byte);
                    errors++;
                end
                if (pc_now !== e.pc)
                begin
                    $display("%0t: pc_now expected %0d actual %0d", $time, e.pc, pc_now);
                    errors++;
                end
            end
        end
    end

    task automatic push_item(input logic [bftm_pkg::CMD_W-1:0] c, input int a, input int b,
                             input bit iv);
        item_t it;
        it.cmd = c;
        it.addr = a[bftm_pkg::ADDR_W-1:0];
        it.cbyte = b[bftm_pkg::BYTE_W-1:0];
        it.iv = iv;
        it.ib = 8'($urandom_range(255));
        item_q.push_back(it);
        n_items++;
    endtask

    task automatic push_step(input bit iv);
        push_item(bftm_pkg::CMD_STEP, $urandom_range(4095), $urandom_range(255), iv);
    endtask

    task automatic wait_drained();
        while (item_q.size() > 0 || item_valid || pending_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bftm_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[bftm_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == bftm_pkg::REG_PROG_LEN) prog_len = val & 'h1FFF;
        else tape_sz = val & 'hFFFF;
    endtask

    function automatic code_q_t to_code(input string s);
        code_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // Load a program, set both registers while idle and queue a start.
    task automatic setup_prog(input code_q_t p, input int tsz, input int plen);
        wait_drained();
        foreach (p[i]) push_item(bftm_pkg::CMD_LOAD, i, p[i], 1'($urandom_range(1)));
        wait_drained();
        write_reg(bftm_pkg::REG_PROG_LEN, plen < 0 ? p.size() : plen);
        write_reg(bftm_pkg::REG_TAPE_SIZE, tsz);
        push_item(bftm_pkg::CMD_START, $urandom_range(4095), $urandom_range(255),
                  1'($urandom_range(1)));
    endtask

    // Mostly well-formed programs: simple commands, filler and small loops.
    function automatic code_q_t gen_prog(input int n, input bit broken);
        code_q_t p;
        int r;
        logic [7:0] body [4];
        body = '{bftm_pkg::CH_RIGHT, bftm_pkg::CH_LEFT, bftm_pkg::CH_DOT,
                 bftm_pkg::CH_MINUS};
        while (p.size() < n)
        begin
            r = $urandom_range(11);
            case (r)
                0, 1: p.push_back(bftm_pkg::CH_PLUS);
                2:    p.push_back(bftm_pkg::CH_MINUS);
                3:    p.push_back(bftm_pkg::CH_RIGHT);
                4:    p.push_back(bftm_pkg::CH_LEFT);
                5:    p.push_back(bftm_pkg::CH_DOT);
                6:    p.push_back(bftm_pkg::CH_COMMA);
                7:    p.push_back(8'($urandom_range(255)));
                default:
                begin
                    p.push_back(bftm_pkg::CH_OPEN);
                    repeat ($urandom_range(1, 3)) p.push_back(body[$urandom_range(3)]);
                    p.push_back(bftm_pkg::CH_MINUS);
                    p.push_back(bftm_pkg::CH_CLOSE);
                end
            endcase
        end
        if (broken)
            p.insert($urandom_range(p.size() - 1),
                     $urandom_range(1) ? bftm_pkg::CH_OPEN : bftm_pkg::CH_CLOSE);
        return p;
    endfunction

    initial
    begin
        code_q_t p;
        int tsz;
        int nsteps;
        int round;
        prog_len = 0;
        tape_sz = bftm_pkg::TAPE_SIZE_RST;
        clear_run();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill the low code addresses and the top one, with no idling on either side.
        calm = 1'b1;
        for (int i = 0; i < 128; i++)
            push_item(bftm_pkg::CMD_LOAD, i, $urandom_range(255), 1'($urandom_range(1)));
        push_item(bftm_pkg::CMD_LOAD, bftm_pkg::CODE_DEPTH_DEF - 1, 255, 1'b1);
        wait_drained();
        calm = 1'b0;

        // Empty program: a step finishes at once; unknown command reports.
        write_reg(bftm_pkg::REG_PROG_LEN, 0);
        push_item(bftm_pkg::CMD_START, 0, 0, 1'b0);
        push_step(1'b1);
        push_item(bftm_pkg::CMD_NOP, 0, 0, 1'b0);

        // Wrapping, output and input with a retry.
        setup_prog(to_code("-.+.,."), bftm_pkg::TAPE_SIZE_RST, -1);
        repeat (4) push_step(1'b1);
        push_step(1'b0);
        repeat (3) push_step(1'b1);

        // Pointer bounds at both ends, sticky.
        setup_prog(to_code("<+"), bftm_pkg::TAPE_SIZE_RST, -1);
        repeat (2) push_step(1'b1);
        setup_prog(to_code(">>."), 0, -1);
        repeat (2) push_step(1'b1);

        // Unmatched brackets.
        setup_prog(to_code("[+"), bftm_pkg::TAPE_SIZE_RST, -1);
        repeat (2) push_step(1'b1);
        setup_prog(to_code("]"), bftm_pkg::TAPE_SIZE_RST, -1);
        push_step(1'b1);

        // Loops with jump cache reuse.
        setup_prog(to_code("++[->+<]>.[[-]]."), bftm_pkg::TAPE_SIZE_RST, -1);
        repeat (24) push_step(1'b1);

        // Tape shrunk below the pointer mid-run.
        setup_prog(to_code(">>>.>"), bftm_pkg::TAPE_SIZE_RST, -1);
        repeat (3) push_step(1'b1);
        wait_drained();
        write_reg(bftm_pkg::REG_TAPE_SIZE, 2);
        repeat (2) push_step(1'b1);

        // Saturating registers.
        setup_prog(to_code(">+."), 16'hFFFF, 16'hFFFF);
        repeat (3) push_step(1'b1);
        setup_prog(to_code("+"), bftm_pkg::TAPE_DEPTH_DEF, bftm_pkg::CODE_DEPTH_DEF);
        repeat (2) push_step(1'b1);

        // Loop stack overflow.
        p = '{bftm_pkg::CH_PLUS};
        repeat (bftm_pkg::STACK_DEPTH_DEF + 1) p.push_back(bftm_pkg::CH_OPEN);
        setup_prog(p, 1, -1);
        repeat (bftm_pkg::STACK_DEPTH_DEF + 2) push_step(1'b1);

        // Random programs with noise between steps, up to the overall item count.
        round = 0;
        while (n_items < 2600)
        begin
            p = gen_prog($urandom_range(4, 40), $urandom_range(9) == 0);
            case ($urandom_range(5))
                0:       tsz = $urandom_range(0, 4);
                1:       tsz = $urandom_range(bftm_pkg::TAPE_DEPTH_DEF, 65535);
                default: tsz = $urandom_range(5, bftm_pkg::TAPE_DEPTH_DEF);
            endcase
            setup_prog(p, tsz, $urandom_range(15) == 0 ? $urandom_range(0, p.size()) : -1);
            nsteps = $urandom_range(10, 60);
            for (int s = 0; s < nsteps; s++)
            begin
                case ($urandom_range(39))
                    0:       push_item(bftm_pkg::CMD_NOP, $urandom_range(4095),
                                       $urandom_range(255), 1'($urandom_range(1)));
                    1:       push_item(bftm_pkg::CMD_LOAD, $urandom_range(p.size() - 1),
                                       $urandom_range(255), 1'($urandom_range(1)));
                    2:       push_item(bftm_pkg::CMD_START, $urandom_range(4095),
                                       $urandom_range(255), 1'($urandom_range(1)));
                    default: push_step($urandom_range(3) != 0);
                endcase
                if (round == 1 && s == 0) hold_req = 1'b1;
            end
            round++;
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("bracket_tape_machine_core test passed");
        else
            $display("bracket_tape_machine_core test failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("bracket_tape_machine_core test failed");
        $finish;
    end

endmodule
